### src/sacd_pkg.sv
// shared types and constants for the set-associative cache directory
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package sacd_pkg;

  localparam int unsigned LineBytes = 16;
  localparam int unsigned Sets      = 64;
  localparam int unsigned Ways      = 4;
  localparam int unsigned OffW      = $clog2(LineBytes);
  localparam int unsigned SetW      = $clog2(Sets);
  localparam int unsigned WayW      = $clog2(Ways);
  localparam int unsigned LineW     = 32 - OffW;
  localparam int unsigned TagW      = LineW - SetW;
  localparam int unsigned MaxRes    = 5;
  localparam int unsigned MaxBytes  = 64;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  localparam logic REG_REPLACE = 1'b0;
  localparam logic REG_WRITE   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;    // take a new access
    logic clear;   // zero counters
    logic rd;      // issue tag read for current line
    logic upd;     // resolve line, update state, capture result
    logic next;    // advance to next line
  } sacd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic more;    // another line remains for this access
  } sacd_sts_t;

  typedef struct packed {
    logic             hit;
    logic [1:0]       way;
    logic             fetch_line;
    logic [27:0]      line_number;
    logic             evict_dirty;
    logic [27:0]      evict_line_number;
    logic             write_memory;
    logic [31:0]      hits_total;
    logic [31:0]      misses_total;
    logic             last;
  } sacd_res_t;

endpackage

### src/set_assoc_cache_directory.sv
// channel   dir  payload
// s_axis    in   tdata: func, address, byte_count
// m_axis    out  tdata: way, line_number, evict_line_number, hits_total, misses_total
//                tuser: hit, fetch_line, evict_dirty, write_memory; tlast: last
// cfg       in   index 0 replace_policy, 1 write-through enable
// each line passes through tag read, resolve and next-line step, in that order;
// an access covers at most 5 lines. the tag memory read port sets the pace.
// clear, unused codes and zero byte counts give no result and leave the controller idle.
// reset needs no clearing pass; a pending result holds while m_axis_tready is low.
// depends on sacd_pkg, sacd_ctrl, sacd_dpath
`timescale 1ns / 1ps

module set_assoc_cache_directory import sacd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // func[1:0], address[33:2], byte_count[40:34]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // way[1:0], line_number[29:2],
                                       // evict_line_number[57:30], hits_total[89:58],
                                       // misses_total[121:90]
  output logic [3:0]   m_axis_tuser,   // hit, fetch_line, evict_dirty, write_memory
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic         cfg_data_i
);

  sacd_cmd_t cmd;
  sacd_sts_t sts;
  sacd_res_t res;
  logic      replace_q, wpol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replace_q <= 1'b0;
      wpol_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REPLACE: replace_q <= cfg_data_i;
        REG_WRITE:   wpol_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sacd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_func_i  (s_axis_tdata[1:0]),
    .in_count_i (s_axis_tdata[40:34]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  sacd_dpath u_dpath (
    .clk_i, .rst_ni,
    .func_i          (s_axis_tdata[1:0]),
    .address_i       (s_axis_tdata[33:2]),
    .byte_count_i    (s_axis_tdata[40:34]),
    .replace_policy_i(replace_q),
    .wr_mode_i       (wpol_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .res_o           (res)
  );

  assign m_axis_tdata = {6'd0, res.misses_total, res.hits_total, res.evict_line_number,
                         res.line_number, res.way};
  assign m_axis_tuser = {res.write_memory, res.evict_dirty, res.fetch_line, res.hit};
  assign m_axis_tlast = res.last;

endmodule

### src/sacd_ctrl.sv
// controller state machine for the cache directory
// depends on sacd_pkg
`timescale 1ns / 1ps

module sacd_ctrl import sacd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [1:0] in_func_i,
  input  logic [6:0] in_count_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sacd_cmd_t cmd_o,
  input  sacd_sts_t sts_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    in_ready_o = 1'b0;
    if (out_ready_i) ovalid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_func_i == FUNC_CLEAR) cmd_o.clear = 1'b1;
          // a zero byte count touches no line
          else if (in_func_i != FUNC_NONE && in_count_i != 7'd0) begin
            cmd_o.load = 1'b1;
            state_d    = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_UPD;
      end
      ST_UPD: begin
        // previous result must be gone before the register is overwritten
        if (!ovalid_q || out_ready_i) begin
          cmd_o.upd = 1'b1;
          ovalid_d  = 1'b1;
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.more) begin
          cmd_o.next = 1'b1;
          state_d    = ST_READ;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

### src/sacd_dpath.sv
// datapath: per-set tag and state rows, counters, lfsr, result register
// depends on sacd_pkg
`timescale 1ns / 1ps

module sacd_dpath import sacd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  func_i,
  input  logic [31:0] address_i,
  input  logic [6:0]  byte_count_i,
  input  logic        replace_policy_i,
  input  logic        wr_mode_i,
  input  sacd_cmd_t   cmd_i,
  output sacd_sts_t   sts_o,
  output sacd_res_t   res_o
);

  localparam int unsigned MetaW = Ways * (WayW + 2);

  // one row per set: tags of all ways; valid, dirty and rank fields
  logic [Ways*TagW-1:0] tag_mem  [Sets];
  logic [MetaW-1:0]     meta_mem [Sets];
  logic [Sets-1:0]      init_q;     // set row written since reset
  logic [Ways*TagW-1:0] rtags_q;
  logic [MetaW-1:0]     rmeta_q;

  logic [1:0]  func_q;
  logic [31:0] addr_q;
  logic [6:0]  left_q, left_d;
  logic [2:0]  n_q;
  logic [31:0] hits_q, misses_q;
  logic [15:0] lfsr_q;
  sacd_res_t   res_q;

  logic [LineW-1:0] line;
  logic [SetW-1:0]  set;
  logic [TagW-1:0]  tag;
  logic [OffW:0]    take;
  logic [6:0]       take7;

  assign line  = addr_q[31:OffW];
  assign set   = line[SetW-1:0];
  assign tag   = line[LineW-1:SetW];
  assign take  = (OffW+1)'(LineBytes) - {1'b0, addr_q[OffW-1:0]};
  assign take7 = 7'(take);
  assign left_d = (take7 > left_q) ? 7'd0 : left_q - take7;

  logic [TagW-1:0] rtag  [Ways];
  logic [Ways-1:0] rvalid, rdirty;
  logic [WayW-1:0] rrank [Ways];

  // a set never written reads as empty, ranks equal to the way index
  always_comb begin
    for (int w = 0; w < Ways; w++) begin
      rtag[w] = rtags_q[w*TagW +: TagW];
      if (init_q[set]) begin
        rvalid[w] = rmeta_q[w];
        rdirty[w] = rmeta_q[Ways + w];
        rrank[w]  = rmeta_q[2*Ways + w*WayW +: WayW];
      end else begin
        rvalid[w] = 1'b0;
        rdirty[w] = 1'b0;
        rrank[w]  = WayW'(w);
      end
    end
  end

  // hit search and victim choice
  logic            hit;
  logic [WayW-1:0] hway, lway, vway, way;
  logic            lfound;
  logic [WayW-1:0] lrank;

  always_comb begin
    hit  = 1'b0;
    hway = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (rvalid[w] && rtag[w] == tag) begin
        hit  = 1'b1;
        hway = WayW'(w);
      end
    end
    // lru: invalid way of lowest rank first, else rank 0
    lfound = 1'b0;
    lway   = '0;
    lrank  = '1;
    for (int w = 0; w < Ways; w++) begin
      if (!rvalid[w] && (!lfound || rrank[w] < lrank)) begin
        lfound = 1'b1;
        lway   = WayW'(w);
        lrank  = rrank[w];
      end
    end
    if (!lfound) begin
      for (int w = 0; w < Ways; w++)
        if (rrank[w] == '0) lway = WayW'(w);
    end
    vway = replace_policy_i ? lfsr_q[WayW-1:0] : lway;
    way  = hit ? hway : vway;
  end

  logic            evict;
  logic [WayW-1:0] wrank;
  assign evict = !hit && rvalid[way] && rdirty[way];
  assign wrank = rrank[way];

  // row written back after the line resolves
  logic [Ways*TagW-1:0] ntags;
  logic [MetaW-1:0]     nmeta;

  always_comb begin
    ntags = rtags_q;
    nmeta = '0;
    for (int w = 0; w < Ways; w++) begin
      nmeta[w]        = rvalid[w];
      nmeta[Ways + w] = rdirty[w];
      nmeta[2*Ways + w*WayW +: WayW] = (rrank[w] > wrank) ? rrank[w] - WayW'(1) : rrank[w];
      if (WayW'(w) == way) begin
        if (!hit) begin
          ntags[w*TagW +: TagW] = tag;
          nmeta[w]              = 1'b1;
          nmeta[Ways + w]       = 1'b0;
        end
        if (func_q == FUNC_WRITE && !wr_mode_i) nmeta[Ways + w] = 1'b1;
        nmeta[2*Ways + w*WayW +: WayW] = WayW'(Ways - 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rtags_q <= tag_mem[set];
      rmeta_q <= meta_mem[set];
    end
    if (cmd_i.upd) begin
      tag_mem[set]  <= ntags;
      meta_mem[set] <= nmeta;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q   <= '0;
      hits_q   <= '0;
      misses_q <= '0;
      lfsr_q   <= 16'hACE1;
    end else if (cmd_i.clear) begin
      hits_q   <= '0;
      misses_q <= '0;
    end else if (cmd_i.upd) begin
      init_q[set] <= 1'b1;
      if (hit) begin
        if (hits_q != '1) hits_q <= hits_q + 32'd1;
      end else begin
        if (misses_q != '1) misses_q <= misses_q + 32'd1;
        if (replace_policy_i)
          lfsr_q <= {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      addr_q <= address_i;
      left_q <= (byte_count_i > 7'(MaxBytes)) ? 7'(MaxBytes) : byte_count_i;
      n_q    <= '0;
    end else if (cmd_i.upd) begin
      left_q <= left_d;
      n_q    <= n_q + 3'd1;
    end else if (cmd_i.next) begin
      addr_q <= {line + LineW'(1), {OffW{1'b0}}};
    end
    if (cmd_i.upd) begin
      res_q.hit               <= hit;
      res_q.way               <= 2'(way);
      res_q.fetch_line        <= !hit;
      res_q.line_number       <= 28'(line);
      res_q.evict_dirty       <= evict;
      res_q.evict_line_number <= evict ? 28'({rtag[way], set}) : 28'd0;
      res_q.write_memory      <= (func_q == FUNC_WRITE) && wr_mode_i;
      res_q.hits_total        <= (hit && hits_q != '1) ? hits_q + 32'd1 : hits_q;
      res_q.misses_total      <= (!hit && misses_q != '1) ? misses_q + 32'd1 : misses_q;
      res_q.last              <= (left_d == 7'd0) || (n_q == 3'(MaxRes - 1));
    end
  end

  assign sts_o.more = (left_q != 7'd0) && (n_q != 3'(MaxRes));
  assign res_o      = res_q;

endmodule

### src/sacd_checker.sv
// port-level checks for the cache directory
// bound to set_assoc_cache_directory
`timescale 1ns / 1ps

module sacd_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [3:0]   m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[1] == !m_axis_tuser[0])
    else $error("fetch_line must be the inverse of hit");

  a_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> !m_axis_tuser[0])
    else $error("eviction on a hit");

  a_noev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata[57:30] == 28'd0)
    else $error("victim line without eviction");

endmodule

bind set_assoc_cache_directory sacd_checker u_chk (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

### verif/tb_top.sv
// self-checking bench for the set-associative cache directory
// predicts each line result from a local copy of tags, ranks and counters; needs sacd_pkg
`timescale 1ns / 1ps

module tb_top;
  import sacd_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [3:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_we_i = 1'b0;
  logic         cfg_idx_i = 1'b0;
  logic         cfg_data_i = 1'b0;

  set_assoc_cache_directory uut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [21:0] tags [Sets*Ways];
  bit          vld  [Sets*Ways];
  bit          drt  [Sets*Ways];
  int unsigned rnk  [Sets*Ways];
  logic [31:0] hit_cnt, miss_cnt;
  logic [15:0] lfsr;
  bit          rand_repl, wr_thru;

  sacd_res_t   lines_due [$];
  int          errors;
  int          send_idle, recv_idle;
  longint      cycles;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  task automatic predict_access(logic [1:0] fn, logic [31:0] addr, logic [6:0] cnt);
    int unsigned left, off, take, base, way, n, r;
    logic [27:0] line;
    logic [21:0] tg;
    bit hit;
    sacd_res_t res;
    left = cnt; n = 0;
    if (fn == FUNC_CLEAR) begin
      hit_cnt = '0; miss_cnt = '0;
      return;
    end
    if (fn == FUNC_NONE) return;
    if (left > MaxBytes) left = MaxBytes;
    while (left > 0 && n < MaxRes) begin
      off = addr % LineBytes;
      line = 28'(addr / LineBytes);
      base = (line % Sets) * Ways;
      tg = 22'(line / Sets);
      hit = 0; way = 0;
      res = '0;
      for (int w = 0; w < Ways; w++)
        if (!hit && vld[base+w] && tags[base+w] == tg) begin
          hit = 1; way = w;
        end
      if (hit) begin
        if (hit_cnt != '1) hit_cnt++;
      end else begin
        if (miss_cnt != '1) miss_cnt++;
        if (rand_repl) begin
          way = lfsr % Ways;
          lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
        end else begin
          way = 0;
          for (int w = 0; w < Ways; w++) if (rnk[base+w] < rnk[base+way]) way = w;
        end
        if (vld[base+way] && drt[base+way]) begin
          res.evict_dirty = 1'b1;
          res.evict_line_number = {tags[base+way], 6'(line % Sets)};
        end
        tags[base+way] = tg; vld[base+way] = 1; drt[base+way] = 0;
      end
      r = rnk[base+way];
      for (int w = 0; w < Ways; w++) if (rnk[base+w] > r) rnk[base+w]--;
      rnk[base+way] = Ways - 1;
      if (fn == FUNC_WRITE && !wr_thru) drt[base+way] = 1;
      take = LineBytes - off;
      if (take > left) take = left;
      left -= take;
      addr = addr - off + LineBytes;
      res.hit = hit; res.way = 2'(way); res.fetch_line = !hit; res.line_number = line;
      res.write_memory = (fn == FUNC_WRITE) && wr_thru;
      res.hits_total = hit_cnt; res.misses_total = miss_cnt;
      res.last = (left == 0 || n == MaxRes - 1);
      lines_due = {lines_due, res};
      n++;
    end
  endtask

  // leaves tvalid high after the transfer; drain() or an idle gap in the next call takes it down
  task automatic send_access(logic [1:0] fn, logic [31:0] addr, logic [6:0] cnt);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= {7'd0, cnt, addr, fn};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_access(fn, addr, cnt);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (lines_due.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic val);
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_REPLACE) rand_repl = val; else wr_thru = val;
  endtask

  // receiver stall pattern
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk_i) begin
    sacd_res_t want;
    cycles++;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (lines_due.size() == 0) begin
        $display("unexpected result transfer");
        errors++;
      end else begin
        want = lines_due.pop_front();
        if (m_axis_tdata[1:0] != want.way)
          report("way", 32'(m_axis_tdata[1:0]), 32'(want.way));
        if (m_axis_tdata[29:2] != want.line_number)
          report("line_number", 32'(m_axis_tdata[29:2]), 32'(want.line_number));
        if (m_axis_tdata[57:30] != want.evict_line_number)
          report("evict_line_number", 32'(m_axis_tdata[57:30]),
                 32'(want.evict_line_number));
        if (m_axis_tdata[89:58] != want.hits_total)
          report("hits_total", m_axis_tdata[89:58], want.hits_total);
        if (m_axis_tdata[121:90] != want.misses_total)
          report("misses_total", m_axis_tdata[121:90], want.misses_total);
        if (m_axis_tuser[0] != want.hit)
          report("hit", 32'(m_axis_tuser[0]), 32'(want.hit));
        if (m_axis_tuser[1] != want.fetch_line)
          report("fetch_line", 32'(m_axis_tuser[1]), 32'(want.fetch_line));
        if (m_axis_tuser[2] != want.evict_dirty)
          report("evict_dirty", 32'(m_axis_tuser[2]), 32'(want.evict_dirty));
        if (m_axis_tuser[3] != want.write_memory)
          report("write_memory", 32'(m_axis_tuser[3]), 32'(want.write_memory));
        if (m_axis_tlast != want.last)
          report("last", 32'(m_axis_tlast), 32'(want.last));
      end
    end
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_access(FUNC_READ, 32'h0, 7'd1);
    send_access(FUNC_READ, 32'h0, 7'd1);
    send_access(FUNC_WRITE, 32'hFFFF_FFF8, 7'd64);   // wraps to line 0
    send_access(FUNC_READ, 32'h0000_0005, 7'd127);   // oversized count
    send_access(FUNC_READ, 32'h1234_5670, 7'd0);     // no line touched
    send_access(FUNC_NONE, 32'hFFFF_FFFF, 7'd64);
    // fill one set past its ways to force dirty evictions
    for (int i = 0; i < 6; i++) send_access(FUNC_WRITE, 32'(i) << 10, 7'd16);
    send_access(FUNC_CLEAR, 32'h0, 7'd1);
    send_access(FUNC_READ, 32'hAAAA_5555, 7'd33);
    send_access(FUNC_WRITE, 32'h5555_AAAA, 7'd64);
  endtask

  task automatic test_saturation();
    drain();
    // the predictor counters are not preloaded, so saturation is not reached; this is
    // limited to checking the clear path and the access that follows
    send_access(FUNC_CLEAR, 32'h0, 7'd1);
    send_access(FUNC_READ, 32'h10, 7'd1);
  endtask

  task automatic test_random(int count);
    logic [31:0] a;
    for (int i = 0; i < count; i++) begin
      a = $urandom();
      if ($urandom_range(3) != 0) a = {a[31:14] & 18'h3, a[13:0]}; // reuse few tags
      case ($urandom_range(19))
        0: send_access(FUNC_CLEAR, a, 7'($urandom()));
        1: send_access(FUNC_NONE, a, 7'($urandom()));
        default: send_access(func_e'($urandom_range(1)), a,
                             ($urandom_range(9) == 0) ? 7'($urandom()) :
                             7'($urandom_range(1, 64)));
      endcase
    end
  endtask

  initial begin
    foreach (vld[i]) begin
      vld[i] = 0; drt[i] = 0; rnk[i] = i % Ways;
    end
    hit_cnt = '0; miss_cnt = '0; lfsr = 16'hACE1;
    rand_repl = 0; wr_thru = 0;
    send_idle = 24; recv_idle = 77;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(20);
    send_idle = 77; recv_idle = 24;
    write_reg(REG_REPLACE, 1'b1);
    test_random(20);
    write_reg(REG_WRITE, 1'b1);
    test_directed();
    send_idle = 0; recv_idle = 0;
    test_saturation();
    write_reg(REG_REPLACE, 1'b0);
    test_random(25);
    write_reg(REG_WRITE, 1'b0);
    test_random(10);
    drain();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
